>>> src/sbcr_pkg.sv
`default_nettype none

package sbcr_pkg;

    localparam int STATION_COUNT = 5;
    localparam int TABLE_DEPTH   = 128;
    localparam int MAX_EXPONENT  = 10;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = $clog2(MAX_EXPONENT + 1);
    localparam int CW = $clog2(STATION_COUNT + 1);

    localparam logic [2:0] SUCCESS_CAP = 3'd5;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_SLOT = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        OC_IDLE      = 3'd0,
        OC_SUCCESS   = 3'd1,
        OC_COLLISION = 3'd2,
        OC_LOADED    = 3'd3,
        OC_DROPPED   = 3'd4
    } t_outcome;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_MATCH,
        S_RESOLVE
    } t_state;

    typedef struct packed {
        t_opcode     opcode;
        logic [30:0] random_word;
    } t_in;

    typedef struct packed {
        t_outcome    outcome;
        logic [2:0]  winner;
        logic [2:0]  contenders;
        logic [31:0] slot_number;
        logic [2:0]  successes;
        logic        all_done;
    } t_out;

    typedef struct packed {
        logic        capture;
        logic [31:0] slot;
        logic [31:0] base;
        logic [30:0] word;
    } t_cell_bus;

    typedef struct packed {
        logic match;
        logic take;
        logic done;
    } t_cell_stat;

endpackage

`default_nettype wire

>>> src/slotted_backoff_collision_resolver.sv
// Channel  | Ports                     | Transfer
// ---------+---------------------------+----------------------------------
// item in  | start, busy, i_item       | edge with start high, busy low
// result   | strobe, o_result          | edge ending the cycle strobe is high
//
// From item to result transfer, a load item passes S_LOAD and the strobe register; a slot
// item without collision passes S_MATCH and the strobe register; one with a collision passes
// S_MATCH, then S_RESOLVE while a token walks the station cells one per cycle, then the
// strobe register; each colliding cell takes one table word from the single table read port.
// busy is low in the strobe cycle. Synchronous active-low reset clears all station state,
// fill, cursor and slot. The table needs no clearing pass; the receiver cannot stall.
`default_nettype none

module slotted_backoff_collision_resolver import sbcr_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      start,
    output logic     busy,
    input  wire t_in i_item,
    output logic     strobe,
    output t_out     o_result
);

    t_state        r_state, n_state;
    t_in           r_in;
    logic [FW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_cursor, n_cursor;
    logic [31:0]   r_cur_slot, n_cur_slot;
    logic [2:0]    r_success, n_success;
    t_out          r_out, n_out;
    logic          r_strobe, n_strobe;
    logic [30:0]   r_rd;
    logic [30:0]   r_mem [TABLE_DEPTH];

    t_cell_bus                w_bus;
    t_cell_stat               w_stat [STATION_COUNT];
    logic [STATION_COUNT:0]   w_tok;
    logic [STATION_COUNT-1:0] w_match, w_take, w_done, w_win;
    logic [CW-1:0]            w_count;
    logic [2:0]               w_first;
    logic                     w_we, w_capture, w_inject;
    logic [FW-1:0]            w_cur_next;

    assign busy = (r_state != S_IDLE);

    genvar g;
    generate
        for (g = 0; g < STATION_COUNT; g++) begin : g_cell
            sbcr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_bus   (w_bus),
                .i_token (w_tok[g]),
                .i_win   (w_win[g]),
                .o_token (w_tok[g+1]),
                .o_stat  (w_stat[g])
            );
            assign w_match[g] = w_stat[g].match;
            assign w_take[g]  = w_stat[g].take;
            assign w_done[g]  = w_stat[g].done;
        end
    endgenerate

    assign w_tok[0] = w_inject;

    always_comb begin
        w_count = '0;
        w_first = '0;
        for (int i = STATION_COUNT - 1; i >= 0; i--) begin
            w_count = w_count + CW'(w_match[i]);
            if (w_match[i]) begin
                w_first = 3'(i);
            end
        end
    end

    always_comb begin
        w_bus.capture = w_capture;
        w_bus.slot    = r_cur_slot;
        w_bus.base    = r_cur_slot;
        w_bus.word    = (r_fill == '0) ? '0 : r_rd;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_item.opcode == OP_LOAD) ? S_LOAD : S_MATCH;
                end
            end
            S_LOAD: begin
                n_state = S_IDLE;
            end
            S_MATCH: begin
                n_state = (w_count > CW'(1)) ? S_RESOLVE : S_IDLE;
            end
            S_RESOLVE: begin
                if (w_tok[STATION_COUNT]) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_fill     = r_fill;
        n_cursor   = r_cursor;
        n_cur_slot = r_cur_slot;
        n_success  = r_success;
        n_out      = r_out;
        n_strobe   = 1'b0;
        w_we       = 1'b0;
        w_capture  = 1'b0;
        w_inject   = 1'b0;
        w_win      = '0;
        w_cur_next = FW'(r_cursor) + FW'(1);
        case (r_state)
            S_LOAD: begin
                n_out             = '0;
                n_strobe          = 1'b1;
                if (r_fill < FW'(TABLE_DEPTH)) begin
                    w_we          = 1'b1;
                    n_fill        = r_fill + FW'(1);
                    n_out.outcome = OC_LOADED;
                end else begin
                    n_out.outcome = OC_DROPPED;
                end
            end
            S_MATCH: begin
                w_capture         = 1'b1;
                n_cur_slot        = r_cur_slot + 32'd1;
                n_out             = '0;
                n_out.slot_number = r_cur_slot;
                n_out.contenders  = 3'(w_count);
                if (w_count == CW'(1)) begin
                    n_out.outcome = OC_SUCCESS;
                    n_out.winner  = w_first;
                    w_win         = w_match;
                    n_strobe      = 1'b1;
                    if (r_success < SUCCESS_CAP) begin
                        n_success = r_success + 3'd1;
                    end
                end else if (w_count > CW'(1)) begin
                    n_out.outcome = OC_COLLISION;
                    w_inject      = 1'b1;
                end else begin
                    n_out.outcome = OC_IDLE;
                    n_strobe      = 1'b1;
                end
            end
            S_RESOLVE: begin
                if ((|w_take) && (r_fill != '0)) begin
                    n_cursor = (w_cur_next >= r_fill) ? '0 : w_cur_next[AW-1:0];
                end
                if (w_tok[STATION_COUNT]) begin
                    n_strobe = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_cursor   <= '0;
            r_cur_slot <= '0;
            r_success  <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_cursor   <= n_cursor;
            r_cur_slot <= n_cur_slot;
            r_success  <= n_success;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_fill[AW-1:0]] <= r_in.random_word;
        end
        r_rd <= r_mem[n_cursor];
    end

    assign strobe = r_strobe;

    always_comb begin
        o_result           = r_out;
        o_result.successes = r_success;
        o_result.all_done  = &w_done;
    end

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |-> $past(r_state) != S_IDLE)
        else $error("result transfer without work");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one token in the cell row");

    a_cursor_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != '0) |-> (FW'(r_cursor) < r_fill))
        else $error("cursor beyond filled table");

    a_take_in_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_take) |-> r_state == S_RESOLVE)
        else $error("table word taken outside resolution");

endmodule

`default_nettype wire

>>> src/sbcr_cell.sv
`default_nettype none

module sbcr_cell import sbcr_pkg::*; (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire t_cell_bus i_bus,
    input  wire            i_token,
    input  wire            i_win,
    output logic           o_token,
    output t_cell_stat     o_stat
);

    logic [31:0]   r_attempt;
    logic [TW-1:0] r_tally;
    logic          r_done;
    logic          r_hit;
    logic          r_token;

    logic          w_match;
    logic [TW-1:0] n_tally;
    logic [30:0]   w_mask;
    logic [31:0]   n_attempt;

    assign w_match = !r_done && (r_attempt == i_bus.slot);

    always_comb begin
        n_tally   = (r_tally < TW'(MAX_EXPONENT)) ? r_tally + 1'b1 : r_tally;
        w_mask    = (31'(1) << n_tally) - 31'(1);
        n_attempt = {1'b0, i_bus.word & w_mask} + i_bus.base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attempt <= '0;
            r_tally   <= '0;
            r_done    <= 1'b0;
            r_hit     <= 1'b0;
            r_token   <= 1'b0;
        end else begin
            r_token <= i_token;
            if (i_bus.capture) begin
                r_hit <= w_match;
            end
            if (i_win) begin
                r_done <= 1'b1;
            end
            if (r_token && r_hit) begin
                r_tally   <= n_tally;
                r_attempt <= n_attempt;
            end
        end
    end

    assign o_token      = r_token;
    assign o_stat.match = w_match;
    assign o_stat.take  = r_token && r_hit;
    assign o_stat.done  = r_done;

    a_take_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.take |-> r_hit && r_token)
        else $error("take without a captured hit");

    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("done flag cleared");

    a_win_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_win |-> w_match && i_bus.capture)
        else $error("win on a non-matching cell");

endmodule

`default_nettype wire
